// ===== design/periodic_event_timer_table_macros.svh =====
`ifndef PERIODIC_EVENT_TIMER_TABLE_MACROS_SVH
`define PERIODIC_EVENT_TIMER_TABLE_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define PETT_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pett assertion failed");

// next-cycle implication, sampled on clk, off during reset
`define PETT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pett assertion failed");

`endif

// ===== design/pett_pkg.sv =====
package pett_pkg;

  localparam int SLOTS_DEF = 16;
  localparam int ID_W      = 8;
  localparam int VAL_W     = 16;
  localparam int FUNC_W    = 2;
  localparam int KIND_W    = 2;
  localparam int STAT_W    = 3;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_TICK = 2'd0,
    FUNC_SET  = 2'd1,
    FUNC_DEL  = 2'd2
  } func_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_STATUS = 2'd0,
    KIND_EVENT  = 2'd1,
    KIND_QUIET  = 2'd2
  } kind_t;

  typedef enum logic [STAT_W-1:0] {
    ST_ADDED     = 3'd0,
    ST_UPDATED   = 3'd1,
    ST_DELETED   = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_FULL      = 3'd4
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_TICK = 1'b1
  } state_t;

  typedef enum logic [1:0] {
    OP_HOLD   = 2'd0,
    OP_ROTATE = 2'd1,
    OP_SET    = 2'd2,
    OP_DEL    = 2'd3
  } cell_op_t;

  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [VAL_W-1:0] period;
    logic [VAL_W-1:0] countdown;
    logic [VAL_W-1:0] remaining;
    logic             started;
    logic             resident;
  } entry_t;

  typedef struct packed {
    cell_op_t        op;
    logic [ID_W-1:0] id;
    logic            any_match;
    entry_t          wr_entry;
    entry_t          head_entry;
    logic            head_expired;
  } cell_ctl_t;

  typedef struct packed {
    logic match;
    logic fired;
    logic expired;
  } cell_stat_t;

endpackage

// ===== design/pett_if.sv =====
interface pett_in_if;
  import pett_pkg::*;

  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [ID_W-1:0]   req_id;
  logic [VAL_W-1:0]  interval;
  logic [VAL_W-1:0]  repeat_count;
  logic              immediate;
  logic              resident;

  modport source (output valid, func, req_id, interval, repeat_count, immediate, resident,
                  input ready);
  modport sink   (input valid, func, req_id, interval, repeat_count, immediate, resident,
                  output ready);
endinterface

interface pett_out_if;
  import pett_pkg::*;

  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [STAT_W-1:0] status;
  logic [ID_W-1:0]   event_id;
  logic              fired;
  logic              expired;
  logic              last;

  modport source (output valid, kind, status, event_id, fired, expired, last, input ready);
  modport sink   (input valid, kind, status, event_id, fired, expired, last, output ready);
endinterface

// ===== design/pett_cell.sv =====
module pett_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  pett_pkg::cell_ctl_t ctl_i,
  input  logic                prv_valid_i,
  input  logic                nxt_valid_i,
  input  pett_pkg::entry_t    nxt_entry_i,
  input  logic                del_i,
  output logic                del_o,
  output logic                valid_o,
  output pett_pkg::entry_t    entry_o,
  output pett_pkg::entry_t    ticked_o,
  output pett_pkg::cell_stat_t stat_o
);
  import pett_pkg::*;

  logic   valid_r, valid_nxt;
  entry_t entry_r, entry_nxt;
  entry_t tk;
  logic   tk_fired, tk_expired;

  // one tick applied to this slot
  always_comb begin
    tk         = entry_r;
    tk_fired   = 1'b0;
    tk_expired = 1'b0;
    if (entry_r.started) begin
      tk_fired = (entry_r.countdown == entry_r.period);
    end else if (entry_r.remaining != {VAL_W{1'b1}}) begin
      tk.remaining = entry_r.remaining + VAL_W'(1);
    end
    tk.started   = 1'b1;
    tk.countdown = entry_r.countdown - VAL_W'(1);
    if (tk.countdown == '0) begin
      tk.countdown = entry_r.period;
    end
    if (!entry_r.resident && tk.countdown == entry_r.period && tk.remaining != '0) begin
      tk_expired   = (tk.remaining == VAL_W'(1));
      tk.remaining = tk.remaining - VAL_W'(1);
    end
  end

  assign stat_o.match   = valid_r && (entry_r.id == ctl_i.id);
  assign stat_o.fired   = valid_r && tk_fired;
  assign stat_o.expired = valid_r && tk_expired;
  assign del_o          = del_i || stat_o.match;
  assign valid_o        = valid_r;
  assign entry_o        = entry_r;
  assign ticked_o       = tk;

  always_comb begin
    valid_nxt = valid_r;
    entry_nxt = entry_r;
    unique case (ctl_i.op)
      OP_ROTATE: begin
        if (nxt_valid_i) begin
          entry_nxt = nxt_entry_i;
        end else if (valid_r) begin
          entry_nxt = ctl_i.head_entry;
          valid_nxt = !ctl_i.head_expired;
        end
      end
      OP_SET: begin
        if (stat_o.match || (!ctl_i.any_match && !valid_r && prv_valid_i)) begin
          entry_nxt = ctl_i.wr_entry;
          valid_nxt = 1'b1;
        end
      end
      OP_DEL: begin
        if (del_o) begin
          entry_nxt = nxt_entry_i;
          valid_nxt = nxt_valid_i;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

// ===== design/periodic_event_timer_table.sv =====
// Set and delete: one status beat, registered in the cycle after the input beat.
// Tick: steps through the occupied slots in turn, holding while the output stalls; one event beat
// per slot that fires or expires; an empty tick or one with no event gives one beat.
// No new input is taken until the tick sweep ends and the output register can take a beat.
// Reset (rst_n low, synchronous) empties the table, the FSM and the output register.
module periodic_event_timer_table #(
  parameter int SLOTS = pett_pkg::SLOTS_DEF
) (
  input  logic  clk,
  input  logic  rst_n,
  pett_in_if.sink    in_ch,
  pett_out_if.source out_ch
);
  import pett_pkg::*;

  localparam int CNT_W = $clog2(SLOTS + 1);

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [CNT_W-1:0]  steps_r, steps_nxt;
  logic              any_r, any_nxt;

  logic              out_valid_r, out_valid_nxt;
  kind_t             kind_r, kind_nxt;
  status_t           status_r, status_nxt;
  logic [ID_W-1:0]   id_r, id_nxt;
  logic              fired_r, fired_nxt;
  logic              expired_r, expired_nxt;
  logic              last_r, last_nxt;

  cell_ctl_t         ctl;
  logic              cell_valid [SLOTS];
  entry_t            cell_entry [SLOTS];
  entry_t            cell_ticked [SLOTS];
  cell_stat_t        cell_stat [SLOTS];
  logic              del_chain [SLOTS+1];

  logic              out_can, in_acc, any_match, head_hit, later_hit, need_out, adv;
  logic [VAL_W-1:0]  period_w;

  assign del_chain[0] = 1'b0;

  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    logic   nv;
    entry_t ne;
    if (i < SLOTS - 1) begin : g_mid
      assign nv = cell_valid[i+1];
      assign ne = cell_entry[i+1];
    end else begin : g_end
      assign nv = 1'b0;
      assign ne = cell_entry[i];
    end
    pett_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctl_i       (ctl),
      .prv_valid_i ((i == 0) ? 1'b1 : cell_valid[(i == 0) ? 0 : i-1]),
      .nxt_valid_i (nv),
      .nxt_entry_i (ne),
      .del_i       (del_chain[i]),
      .del_o       (del_chain[i+1]),
      .valid_o     (cell_valid[i]),
      .entry_o     (cell_entry[i]),
      .ticked_o    (cell_ticked[i]),
      .stat_o      (cell_stat[i])
    );
  end

  assign out_can     = !out_valid_r || out_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE) && out_can;
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign head_hit    = cell_stat[0].fired || cell_stat[0].expired;
  assign need_out    = head_hit || (steps_r == CNT_W'(1) && !any_r);
  assign adv         = (state_r == S_TICK) && (!need_out || out_can);
  assign period_w    = (in_ch.interval == '0) ? VAL_W'(1) : in_ch.interval;

  always_comb begin
    any_match = 1'b0;
    later_hit = 1'b0;
    for (int j = 0; j < SLOTS; j++) begin
      any_match = any_match || cell_stat[j].match;
      if (j > 0 && CNT_W'(j) < steps_r) begin
        later_hit = later_hit || cell_stat[j].fired || cell_stat[j].expired;
      end
    end
  end

  always_comb begin
    ctl.op                  = OP_HOLD;
    ctl.id                  = in_ch.req_id;
    ctl.any_match           = any_match;
    ctl.wr_entry.id         = in_ch.req_id;
    ctl.wr_entry.period     = period_w;
    ctl.wr_entry.countdown  = period_w;
    ctl.wr_entry.remaining  = in_ch.repeat_count;
    ctl.wr_entry.started    = in_ch.immediate;
    ctl.wr_entry.resident   = in_ch.resident;
    ctl.head_entry          = cell_ticked[0];
    ctl.head_expired        = cell_stat[0].expired;

    state_nxt     = state_r;
    count_nxt     = count_r;
    steps_nxt     = steps_r;
    any_nxt       = any_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    kind_nxt      = kind_r;
    status_nxt    = status_r;
    id_nxt        = id_r;
    fired_nxt     = fired_r;
    expired_nxt   = expired_r;
    last_nxt      = last_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          kind_nxt    = KIND_STATUS;
          status_nxt  = ST_ADDED;
          id_nxt      = in_ch.req_id;
          fired_nxt   = 1'b0;
          expired_nxt = 1'b0;
          last_nxt    = 1'b1;
          unique case (in_ch.func)
            FUNC_SET: begin
              ctl.op        = OP_SET;
              out_valid_nxt = 1'b1;
              if (any_match) begin
                status_nxt = ST_UPDATED;
              end else if (count_r == CNT_W'(SLOTS)) begin
                status_nxt = ST_FULL;
              end else begin
                count_nxt = count_r + CNT_W'(1);
              end
            end
            FUNC_DEL: begin
              ctl.op        = OP_DEL;
              out_valid_nxt = 1'b1;
              if (any_match) begin
                status_nxt = ST_DELETED;
                count_nxt  = count_r - CNT_W'(1);
              end else begin
                status_nxt = ST_NOT_FOUND;
              end
            end
            FUNC_TICK: begin
              if (count_r == '0) begin
                out_valid_nxt = 1'b1;
                kind_nxt      = KIND_QUIET;
                id_nxt        = '0;
              end else begin
                state_nxt = S_TICK;
                steps_nxt = count_r;
                any_nxt   = 1'b0;
              end
            end
            default: ;
          endcase
        end
      end
      S_TICK: begin
        if (adv) begin
          ctl.op    = OP_ROTATE;
          steps_nxt = steps_r - CNT_W'(1);
          any_nxt   = any_r || head_hit;
          if (cell_stat[0].expired) begin
            count_nxt = count_r - CNT_W'(1);
          end
          if (head_hit) begin
            out_valid_nxt = 1'b1;
            kind_nxt      = KIND_EVENT;
            status_nxt    = ST_ADDED;
            id_nxt        = cell_entry[0].id;
            fired_nxt     = cell_stat[0].fired;
            expired_nxt   = cell_stat[0].expired;
            last_nxt      = !later_hit;
          end else if (need_out) begin
            out_valid_nxt = 1'b1;
            kind_nxt      = KIND_QUIET;
            status_nxt    = ST_ADDED;
            id_nxt        = '0;
            fired_nxt     = 1'b0;
            expired_nxt   = 1'b0;
            last_nxt      = 1'b1;
          end
          if (steps_r == CNT_W'(1)) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      steps_r     <= '0;
      any_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      steps_r     <= steps_nxt;
      any_r       <= any_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r    <= kind_nxt;
    status_r  <= status_nxt;
    id_r      <= id_nxt;
    fired_r   <= fired_nxt;
    expired_r <= expired_nxt;
    last_r    <= last_nxt;
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.kind     = kind_r;
  assign out_ch.status   = status_r;
  assign out_ch.event_id = id_r;
  assign out_ch.fired    = fired_r;
  assign out_ch.expired  = expired_r;
  assign out_ch.last     = last_r;

endmodule

// ===== design/pett_chk.sv =====
`include "periodic_event_timer_table_macros.svh"

module pett_chk (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic [pett_pkg::FUNC_W-1:0] in_func,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [pett_pkg::KIND_W-1:0] out_kind,
  input logic [pett_pkg::ID_W-1:0]   out_event_id,
  input logic                        out_last
);
  import pett_pkg::*;

  logic in_acc;
  assign in_acc = in_valid && in_ready;

  `PETT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
  `PETT_ASSERT_NEXT(a_req_status, in_acc && (in_func == FUNC_SET || in_func == FUNC_DEL), out_valid && out_kind == KIND_STATUS && out_last)
  `PETT_ASSERT_NOW(a_no_accept_mid_tick, out_valid && out_kind == KIND_EVENT && !out_last, !in_ready)
  `PETT_ASSERT_NOW(a_quiet_beat, out_valid && out_kind == KIND_QUIET, out_last && out_event_id == '0)

endmodule

bind periodic_event_timer_table pett_chk u_pett_chk (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .in_func      (in_ch.func),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .out_kind     (out_ch.kind),
  .out_event_id (out_ch.event_id),
  .out_last     (out_ch.last)
);

// ===== dv/tb_periodic_event_timer_table.sv =====
`timescale 1ns / 1ps

module tb_periodic_event_timer_table;
  import pett_pkg::*;

  localparam int SLOTS = SLOTS_DEF;
  localparam int IDLE_LIMIT = 3000;
  localparam int TAIL_CYCLES = 4 * SLOTS;
  localparam int RANDOM_PER_PHASE = 115;
  localparam logic [FUNC_W-1:0] FUNC_SPARE = 2'd3;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [STAT_W-1:0] status;
    logic [ID_W-1:0]   event_id;
    logic              fired;
    logic              expired;
    logic              last;
  } timer_beat_t;

  class timer_table_scoreboard;
    logic [ID_W-1:0]  slot_id        [SLOTS];
    logic [VAL_W-1:0] slot_period    [SLOTS];
    logic [VAL_W-1:0] slot_countdown [SLOTS];
    logic [VAL_W-1:0] slot_remaining [SLOTS];
    logic             slot_started   [SLOTS];
    logic             slot_resident  [SLOTS];
    int               used;
    timer_beat_t      batch [SLOTS+1];
    int               batch_len;
    timer_beat_t      pending [$];
    int               errors;

    function new();
      used = 0;
      errors = 0;
    endfunction

    function void stage(kind_t kind, status_t status, logic [ID_W-1:0] id,
                        logic fired, logic expired);
      batch[batch_len] = '{kind, status, id, fired, expired, 1'b0};
      batch_len = batch_len + 1;
    endfunction

    function int lookup(logic [ID_W-1:0] id);
      for (int i = 0; i < used; i++) begin
        if (slot_id[i] == id) return i;
      end
      return -1;
    endfunction

    function void drop_slot(int idx);
      for (int j = idx; j + 1 < used; j++) begin
        slot_id[j]        = slot_id[j+1];
        slot_period[j]    = slot_period[j+1];
        slot_countdown[j] = slot_countdown[j+1];
        slot_remaining[j] = slot_remaining[j+1];
        slot_started[j]   = slot_started[j+1];
        slot_resident[j]  = slot_resident[j+1];
      end
      used = used - 1;
    endfunction

    function void note_request(logic [FUNC_W-1:0] func, logic [ID_W-1:0] id,
                               logic [VAL_W-1:0] ivl, logic [VAL_W-1:0] cnt,
                               logic imm, logic res);
      int i;
      logic fire;
      logic expire;
      batch_len = 0;
      case (func)
        FUNC_TICK: begin
          i = 0;
          while (i < used) begin
            fire = 1'b0;
            expire = 1'b0;
            if (slot_started[i]) begin
              fire = (slot_countdown[i] == slot_period[i]);
            end else begin
              if (slot_remaining[i] != '1) slot_remaining[i] = slot_remaining[i] + 1'b1;
              slot_started[i] = 1'b1;
            end
            slot_countdown[i] = slot_countdown[i] - 1'b1;
            if (slot_countdown[i] == '0) slot_countdown[i] = slot_period[i];
            if (!slot_resident[i] && slot_countdown[i] == slot_period[i] &&
                slot_remaining[i] != '0) begin
              slot_remaining[i] = slot_remaining[i] - 1'b1;
              expire = (slot_remaining[i] == '0);
            end
            if (fire || expire) stage(KIND_EVENT, ST_ADDED, slot_id[i], fire, expire);
            if (expire) drop_slot(i);
            else i = i + 1;
          end
          if (batch_len == 0) stage(KIND_QUIET, ST_ADDED, '0, 1'b0, 1'b0);
        end
        FUNC_SET: begin
          i = lookup(id);
          if (i < 0 && used >= SLOTS) begin
            stage(KIND_STATUS, ST_FULL, id, 1'b0, 1'b0);
          end else begin
            if (i < 0) begin
              i = used;
              used = used + 1;
              slot_id[i] = id;
              stage(KIND_STATUS, ST_ADDED, id, 1'b0, 1'b0);
            end else begin
              stage(KIND_STATUS, ST_UPDATED, id, 1'b0, 1'b0);
            end
            slot_period[i]    = (ivl == '0) ? VAL_W'(1) : ivl;
            slot_countdown[i] = slot_period[i];
            slot_remaining[i] = cnt;
            slot_started[i]   = imm;
            slot_resident[i]  = res;
          end
        end
        FUNC_DEL: begin
          i = lookup(id);
          if (i >= 0) begin
            drop_slot(i);
            stage(KIND_STATUS, ST_DELETED, id, 1'b0, 1'b0);
          end else begin
            stage(KIND_STATUS, ST_NOT_FOUND, id, 1'b0, 1'b0);
          end
        end
        default: ;
      endcase
      if (batch_len > 0) batch[batch_len-1].last = 1'b1;
      for (int j = 0; j < batch_len; j++) pending.push_back(batch[j]);
    endfunction

    function void check_beat(timer_beat_t got);
      timer_beat_t want;
      if (pending.size() == 0) begin
        errors = errors + 1;
        if (errors <= 10)
          $display("%0t: unexpected result kind=%0d status=%0d id=%0d",
                   $realtime, got.kind, got.status, got.event_id,
                   " fired=%b expired=%b last=%b", got.fired, got.expired, got.last);
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        errors = errors + 1;
        if (errors <= 10)
          $display("%0t: mismatch exp kind=%0d status=%0d id=%0d fired=%b expired=%b last=%b",
                   $realtime, want.kind, want.status, want.event_id, want.fired,
                   want.expired, want.last,
                   " | act kind=%0d status=%0d id=%0d fired=%b expired=%b last=%b",
                   got.kind, got.status, got.event_id, got.fired, got.expired, got.last);
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  int   idle_pct;
  int   stall_pct;
  int   quiet_cycles;

  timer_table_scoreboard sb;

  pett_in_if  in_ch ();
  pett_out_if out_ch ();

  periodic_event_timer_table #(.SLOTS(SLOTS)) i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(negedge clk) begin
    out_ch.ready = ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready)
        sb.note_request(in_ch.func, in_ch.req_id, in_ch.interval, in_ch.repeat_count,
                        in_ch.immediate, in_ch.resident);
      if (out_ch.valid && out_ch.ready)
        sb.check_beat('{out_ch.kind, out_ch.status, out_ch.event_id, out_ch.fired,
                        out_ch.expired, out_ch.last});
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= IDLE_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // called at a falling edge; returns at the falling edge after the beat
  task automatic send_request(logic [FUNC_W-1:0] func, logic [ID_W-1:0] id,
                              logic [VAL_W-1:0] ivl, logic [VAL_W-1:0] cnt,
                              logic imm, logic res);
    while ($urandom_range(99) < idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid        = 1'b1;
    in_ch.func         = func;
    in_ch.req_id       = id;
    in_ch.interval     = ivl;
    in_ch.repeat_count = cnt;
    in_ch.immediate    = imm;
    in_ch.resident     = res;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_ch.valid = 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic random_request();
    logic [FUNC_W-1:0] func;
    logic [ID_W-1:0]   id;
    logic [VAL_W-1:0]  ivl;
    logic [VAL_W-1:0]  cnt;
    int                pick;
    pick = $urandom_range(99);
    if (pick < 40) func = FUNC_TICK;
    else if (pick < 72) func = FUNC_SET;
    else if (pick < 96) func = FUNC_DEL;
    else func = FUNC_SPARE;
    id = ($urandom_range(9) == 0) ? ID_W'($urandom_range(255)) : ID_W'($urandom_range(23));
    case ($urandom_range(19))
      0: ivl = VAL_W'($urandom);
      1: ivl = '0;
      default: ivl = VAL_W'($urandom_range(6, 1));
    endcase
    case ($urandom_range(19))
      0: cnt = VAL_W'($urandom);
      1: cnt = '1;
      2: cnt = '0;
      default: cnt = VAL_W'($urandom_range(5, 1));
    endcase
    send_request(func, id, ivl, cnt, 1'($urandom), 1'($urandom));
  endtask

  initial begin
    sb = new();
    idle_pct = 0;
    stall_pct = 0;
    quiet_cycles = 0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.func = FUNC_TICK;
    in_ch.req_id = '0;
    in_ch.interval = '0;
    in_ch.repeat_count = '0;
    in_ch.immediate = 1'b0;
    in_ch.resident = 1'b0;
    out_ch.ready = 1'b0;
    repeat (9) @(negedge clk);
    rst_n = 1'b1;

    // directed
    send_request(FUNC_TICK, 8'd0, '0, '0, 1'b0, 1'b0);
    send_request(FUNC_SPARE, 8'd3, 16'd5, 16'd5, 1'b1, 1'b1);
    send_request(FUNC_DEL, 8'd7, '0, '0, 1'b0, 1'b0);
    send_request(FUNC_SET, 8'd0, '0, 16'd1, 1'b1, 1'b0);
    send_request(FUNC_SET, 8'd255, '1, '1, 1'b0, 1'b0);
    send_request(FUNC_SET, 8'd1, 16'd2, 16'd1, 1'b0, 1'b0);
    send_request(FUNC_TICK, '1, '1, '1, 1'b1, 1'b1);
    send_request(FUNC_SET, 8'd2, 16'd1, '0, 1'b1, 1'b0);
    send_request(FUNC_TICK, 8'd0, '0, '0, 1'b0, 1'b0);
    send_request(FUNC_TICK, 8'd0, '0, '0, 1'b0, 1'b0);
    send_request(FUNC_SET, 8'd255, 16'd3, 16'd2, 1'b1, 1'b1);
    send_request(FUNC_DEL, 8'd255, '0, '0, 1'b0, 1'b0);
    for (int j = 3; j <= 17; j++)
      send_request(FUNC_SET, ID_W'(j), 16'd1, '0, 1'b1, 1'b1);
    send_request(FUNC_TICK, 8'd0, '0, '0, 1'b0, 1'b0);
    drain_results();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 70; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 70; end
        default: begin idle_pct = 21; stall_pct = 21; end
      endcase
      repeat (RANDOM_PER_PHASE) random_request();
      drain_results();
    end

    idle_pct = 0;
    stall_pct = 0;
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
